/* hdl/ebc_pkg.sv */
// ----------------------------------------------------------------------------
// ebc_pkg: shared types and constants for the ball collision response unit
// Beat structs, datapath widths and fixed-point constants.
// ----------------------------------------------------------------------------
package ebc_pkg;

	// Datapath widths
	localparam int DIFF_W     = 33;  // center and velocity differences
	localparam int NRM_W      = 14;  // normalized direction magnitude
	localparam int NRM_MSB    = 13;  // target leading-one position of the direction
	localparam int NUM_W      = 62;  // divider dividend
	localparam int DEN_W      = 33;  // divider divisor
	localparam int QUOT_W     = 34;  // divider quotient
	localparam int DIV_STAGES = QUOT_W;
	localparam int FACT_W     = 30;  // mass factor, Q2.28
	localparam int MASS_FRAC  = 28;
	localparam int ELAST_FRAC = 16;
	localparam int PRE_STAGES = 7;
	localparam int POST_STAGES = 7;
	localparam int LATENCY    = PRE_STAGES + DIV_STAGES + POST_STAGES;

	localparam logic [FACT_W-1:0] FACT_ONE = FACT_W'(1) << MASS_FRAC;
	localparam logic [FACT_W-1:0] FACT_TWO = FACT_W'(1) << (MASS_FRAC + 1);
	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] ball_a_x;
		logic signed [31:0] ball_a_y;
		logic signed [31:0] ball_b_x;
		logic signed [31:0] ball_b_y;
		logic signed [31:0] ball_a_vx;
		logic signed [31:0] ball_a_vy;
		logic signed [31:0] ball_b_vx;
		logic signed [31:0] ball_b_vy;
		logic [31:0]        ball_a_mass;
		logic [31:0]        ball_b_mass;
		logic [16:0]        ball_a_restitution;
		logic [16:0]        ball_b_restitution;
	} item_t;

	typedef struct packed {
		logic signed [31:0] new_a_vx;
		logic signed [31:0] new_a_vy;
		logic signed [31:0] new_b_vx;
		logic signed [31:0] new_b_vy;
		logic               centers_coincide;
		logic               saturated;
	} result_t;

	// Position of the highest set bit, zero for an empty word
	function automatic logic [5:0] lead_pos(input logic [DIFF_W-1:0] m);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < DIFF_W; i++) begin
			if (m[i]) p = 6'(i);
		end
		return p;
	endfunction

endpackage

/* hdl/ebc_div.sv */
// ----------------------------------------------------------------------------
// ebc_div: pipelined unsigned restoring divider
// One quotient bit per stage; the quotient must fit in QUOT_W bits.
// ----------------------------------------------------------------------------
module ebc_div import ebc_pkg::*; (
	input  logic              clk,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [QUOT_W-1:0] quot,
	output logic              rem_nz
);

	logic [DEN_W-1:0]  part_s [DIV_STAGES];
	logic [QUOT_W-1:0] low_s  [DIV_STAGES];
	logic [QUOT_W-1:0] quo_s  [DIV_STAGES];
	logic [DEN_W-1:0]  dvs_s  [DIV_STAGES];

	genvar k;
	generate
		for (k = 0; k < DIV_STAGES; k++) begin : g_step
			logic [DEN_W-1:0]  part_in;
			logic [DEN_W-1:0]  dvs_in;
			logic [QUOT_W-1:0] low_in;
			logic [QUOT_W-1:0] quo_in;
			logic [DEN_W:0]    trial;
			logic [DEN_W:0]    diff;
			logic              ge;

			// Seed with the top dividend bits, then take stage outputs
			if (k == 0) begin : g_first
				assign part_in = DEN_W'(num[NUM_W-1:QUOT_W]);
				assign low_in  = num[QUOT_W-1:0];
				assign quo_in  = '0;
				assign dvs_in  = den;
			end else begin : g_next
				assign part_in = part_s[k-1];
				assign low_in  = low_s[k-1];
				assign quo_in  = quo_s[k-1];
				assign dvs_in  = dvs_s[k-1];
			end

			// Shift in the next dividend bit, trial subtract
			assign trial = {part_in, low_in[QUOT_W-1]};
			assign diff  = trial - {1'b0, dvs_in};
			assign ge    = (trial >= {1'b0, dvs_in});

			always_ff @(posedge clk) begin
				part_s[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				low_s[k]  <= {low_in[QUOT_W-2:0], 1'b0};
				quo_s[k]  <= {quo_in[QUOT_W-2:0], ge};
				dvs_s[k]  <= dvs_in;
			end
		end
	endgenerate

	assign quot   = quo_s[DIV_STAGES-1];
	assign rem_nz = |part_s[DIV_STAGES-1];

endmodule

/* hdl/elastic_ball_collision_response_unit.sv */
// ----------------------------------------------------------------------------
// elastic_ball_collision_response_unit: two-ball 2D collision response
// Exchanges momentum along the line of centers, scales by elasticity and
// saturates each new velocity to 32 bits.
// ----------------------------------------------------------------------------
//  channel   ports                   beat
//  request   start, busy, item       item_t, taken when start && !busy
//  result    done, result            result_t, valid for one cycle
//
// One pair enters per cycle; busy is always low.
// The pipeline has 7 front stages, 34 divider stages (one quotient
// bit each, in the projection and mass-factor dividers), 7 back stages.
// Reset clears only the valid line; data stages run free.
// The result side has no back pressure, so nothing ever stalls.
module elastic_ball_collision_response_unit import ebc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam int LANES = 4;  // a.x, a.y, b.x, b.y

	typedef struct packed {
		logic signed [31:0] avx;
		logic signed [31:0] avy;
		logic signed [31:0] bvx;
		logic signed [31:0] bvy;
		logic [16:0]        ea;
		logic [16:0]        eb;
	} carry_t;

	typedef struct packed {
		carry_t cr;
		logic   coin;
		logic   tz;
		logic   sgx;
		logic   sgy;
	} side_t;

	// Valid line
	logic [LATENCY-1:0] valid_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[LATENCY-2:0], start};
		end
	end

	assign busy = 1'b0;
	assign done = valid_s[LATENCY-1];

	// Stage 1: differences and mass total
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [DIFF_W-1:0]        tot_s1;
	logic [31:0]              mb_s1;
	carry_t                   cr_s1;

	always_ff @(posedge clk) begin
		dx_s1  <= {item.ball_a_x[31], item.ball_a_x} - {item.ball_b_x[31], item.ball_b_x};
		dy_s1  <= {item.ball_a_y[31], item.ball_a_y} - {item.ball_b_y[31], item.ball_b_y};
		dvx_s1 <= {item.ball_a_vx[31], item.ball_a_vx} - {item.ball_b_vx[31], item.ball_b_vx};
		dvy_s1 <= {item.ball_a_vy[31], item.ball_a_vy} - {item.ball_b_vy[31], item.ball_b_vy};
		tot_s1 <= {1'b0, item.ball_a_mass} + {1'b0, item.ball_b_mass};
		mb_s1  <= item.ball_b_mass;
		cr_s1  <= '{avx: item.ball_a_vx, avy: item.ball_a_vy,
			bvx: item.ball_b_vx, bvy: item.ball_b_vy,
			ea: item.ball_a_restitution, eb: item.ball_b_restitution};
	end

	// Stage 2: magnitudes and normalizing shift
	logic [DIFF_W-1:0] adx_c, ady_c, mx_c;
	logic [5:0]        lp_c;
	logic [DIFF_W-1:0] adx_s2, ady_s2;
	logic              sx_s2, sy_s2, shr_s2, coin_s2;
	logic [4:0]        amt_s2;
	logic signed [DIFF_W-1:0] dvx_s2, dvy_s2;
	logic [DIFF_W-1:0] tot_s2;
	logic [31:0]       mb_s2;
	carry_t            cr_s2;

	always_comb begin
		adx_c = dx_s1[DIFF_W-1] ? DIFF_W'(-dx_s1) : DIFF_W'(dx_s1);
		ady_c = dy_s1[DIFF_W-1] ? DIFF_W'(-dy_s1) : DIFF_W'(dy_s1);
		mx_c  = (adx_c > ady_c) ? adx_c : ady_c;
		lp_c  = lead_pos(mx_c);
	end

	always_ff @(posedge clk) begin
		adx_s2  <= adx_c;
		ady_s2  <= ady_c;
		sx_s2   <= dx_s1[DIFF_W-1];
		sy_s2   <= dy_s1[DIFF_W-1];
		shr_s2  <= (lp_c >= 6'(NRM_MSB));
		amt_s2  <= (lp_c >= 6'(NRM_MSB)) ? 5'(lp_c - 6'(NRM_MSB)) : 5'(6'(NRM_MSB) - lp_c);
		coin_s2 <= (mx_c == '0);
		dvx_s2  <= dvx_s1;
		dvy_s2  <= dvy_s1;
		tot_s2  <= tot_s1;
		mb_s2   <= mb_s1;
		cr_s2   <= cr_s1;
	end

	// Stage 3: normalize direction to a 14-bit magnitude
	logic [NRM_W-1:0]        nmx_s3, nmy_s3;
	logic signed [NRM_W:0]   ndx_s3, ndy_s3;
	logic [NRM_W-1:0]        nmx_c, nmy_c;
	logic                    sx_s3, sy_s3, coin_s3;
	logic signed [DIFF_W-1:0] dvx_s3, dvy_s3;
	logic [DIFF_W-1:0]       tot_s3;
	logic [31:0]             mb_s3;
	carry_t                  cr_s3;

	always_comb begin
		nmx_c = shr_s2 ? NRM_W'(adx_s2 >> amt_s2) : NRM_W'(adx_s2 << amt_s2);
		nmy_c = shr_s2 ? NRM_W'(ady_s2 >> amt_s2) : NRM_W'(ady_s2 << amt_s2);
	end

	always_ff @(posedge clk) begin
		nmx_s3  <= nmx_c;
		nmy_s3  <= nmy_c;
		ndx_s3  <= sx_s2 ? -$signed({1'b0, nmx_c}) : $signed({1'b0, nmx_c});
		ndy_s3  <= sy_s2 ? -$signed({1'b0, nmy_c}) : $signed({1'b0, nmy_c});
		sx_s3   <= sx_s2;
		sy_s3   <= sy_s2;
		coin_s3 <= coin_s2;
		dvx_s3  <= dvx_s2;
		dvy_s3  <= dvy_s2;
		tot_s3  <= tot_s2;
		mb_s3   <= mb_s2;
		cr_s3   <= cr_s2;
	end

	// Stage 4: dot and norm products
	logic signed [47:0] pvx_s4, pvy_s4;
	logic [27:0]        sqx_s4, sqy_s4;
	logic [NRM_W-1:0]   nmx_s4, nmy_s4;
	logic               sx_s4, sy_s4, coin_s4;
	logic [DIFF_W-1:0]  tot_s4;
	logic [31:0]        mb_s4;
	carry_t             cr_s4;

	always_ff @(posedge clk) begin
		pvx_s4  <= dvx_s3 * ndx_s3;
		pvy_s4  <= dvy_s3 * ndy_s3;
		sqx_s4  <= nmx_s3 * nmx_s3;
		sqy_s4  <= nmy_s3 * nmy_s3;
		nmx_s4  <= nmx_s3;
		nmy_s4  <= nmy_s3;
		sx_s4   <= sx_s3;
		sy_s4   <= sy_s3;
		coin_s4 <= coin_s3;
		tot_s4  <= tot_s3;
		mb_s4   <= mb_s3;
		cr_s4   <= cr_s3;
	end

	// Stage 5: sum into dot and squared norm
	logic signed [48:0] dot_s5;
	logic [28:0]        n2_s5;
	logic [NRM_W-1:0]   nmx_s5, nmy_s5;
	logic               sx_s5, sy_s5, coin_s5;
	logic [DIFF_W-1:0]  tot_s5;
	logic [31:0]        mb_s5;
	carry_t             cr_s5;

	always_ff @(posedge clk) begin
		dot_s5  <= {pvx_s4[47], pvx_s4} + {pvy_s4[47], pvy_s4};
		n2_s5   <= {1'b0, sqx_s4} + {1'b0, sqy_s4};
		nmx_s5  <= nmx_s4;
		nmy_s5  <= nmy_s4;
		sx_s5   <= sx_s4;
		sy_s5   <= sy_s4;
		coin_s5 <= coin_s4;
		tot_s5  <= tot_s4;
		mb_s5   <= mb_s4;
		cr_s5   <= cr_s4;
	end

	// Stage 6: dot magnitude
	logic [47:0]       dmag_s6;
	logic              dsg_s6;
	logic [28:0]       n2_s6;
	logic [NRM_W-1:0]  nmx_s6, nmy_s6;
	logic              sx_s6, sy_s6, coin_s6;
	logic [DIFF_W-1:0] tot_s6;
	logic [31:0]       mb_s6;
	carry_t            cr_s6;

	always_ff @(posedge clk) begin
		dmag_s6 <= dot_s5[48] ? 48'(-dot_s5) : 48'(dot_s5);
		dsg_s6  <= dot_s5[48];
		n2_s6   <= n2_s5;
		nmx_s6  <= nmx_s5;
		nmy_s6  <= nmy_s5;
		sx_s6   <= sx_s5;
		sy_s6   <= sy_s5;
		coin_s6 <= coin_s5;
		tot_s6  <= tot_s5;
		mb_s6   <= mb_s5;
		cr_s6   <= cr_s5;
	end

	// Stage 7: divider operands
	logic [NUM_W-1:0] numx_s7, numy_s7, numm_s7;
	logic [DEN_W-1:0] n2_s7, tot_s7;
	side_t            side_s7;

	always_ff @(posedge clk) begin
		numx_s7 <= nmx_s6 * dmag_s6;
		numy_s7 <= nmy_s6 * dmag_s6;
		numm_s7 <= NUM_W'({mb_s6, 29'b0});
		n2_s7   <= DEN_W'(n2_s6);
		tot_s7  <= tot_s6;
		side_s7 <= '{cr: cr_s6, coin: coin_s6, tz: (tot_s6 == '0),
			sgx: sx_s6 ^ dsg_s6, sgy: sy_s6 ^ dsg_s6};
	end

	// Projection and mass-factor dividers
	logic [QUOT_W-1:0] qx, qy, qm;
	logic              rnz_x, rnz_y, rnz_m;

	ebc_div u_div_x (.clk(clk), .num(numx_s7), .den(n2_s7), .quot(qx), .rem_nz(rnz_x));
	ebc_div u_div_y (.clk(clk), .num(numy_s7), .den(n2_s7), .quot(qy), .rem_nz(rnz_y));
	ebc_div u_div_m (.clk(clk), .num(numm_s7), .den(tot_s7), .quot(qm), .rem_nz(rnz_m));

	// Side data rides alongside the dividers
	side_t side_s [DIV_STAGES];

	always_ff @(posedge clk) begin
		side_s[0] <= side_s7;
		for (int k = 1; k < DIV_STAGES; k++) begin
			side_s[k] <= side_s[k-1];
		end
	end

	side_t side_d;
	assign side_d = side_s[DIV_STAGES-1];

	// Stage 8: mass factors, lane setup
	logic [FACT_W-1:0] fa_c, fb_c;
	logic [QUOT_W-1:0] lmag_s8 [LANES];
	logic [FACT_W-1:0] lfac_s8 [LANES];
	logic              lsg_s8  [LANES];
	logic              tz_s8, coin_s8;
	carry_t            cr_s8;

	always_comb begin
		fa_c = side_d.tz ? FACT_ONE : qm[FACT_W-1:0];
		fb_c = side_d.tz ? FACT_ONE : FACT_TWO - qm[FACT_W-1:0] - FACT_W'(rnz_m);
	end

	always_ff @(posedge clk) begin
		lmag_s8[0] <= qx;
		lmag_s8[1] <= qy;
		lmag_s8[2] <= qx;
		lmag_s8[3] <= qy;
		lfac_s8[0] <= fa_c;
		lfac_s8[1] <= fa_c;
		lfac_s8[2] <= fb_c;
		lfac_s8[3] <= fb_c;
		lsg_s8[0]  <= side_d.sgx & (|qx);
		lsg_s8[1]  <= side_d.sgy & (|qy);
		lsg_s8[2]  <= side_d.sgx & (|qx);
		lsg_s8[3]  <= side_d.sgy & (|qy);
		tz_s8      <= side_d.tz;
		coin_s8    <= side_d.coin;
		cr_s8      <= side_d.cr;
	end

	// Stage 9: split products of projection and mass factor
	logic [46:0] plo_s9 [LANES];
	logic [46:0] phi_s9 [LANES];
	logic        lsg_s9 [LANES];
	logic        coin_s9;
	carry_t      cr_s9;

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			plo_s9[l] <= lmag_s8[l][16:0] * lfac_s8[l];
			phi_s9[l] <= lmag_s8[l][QUOT_W-1:17] * lfac_s8[l];
			lsg_s9[l] <= lsg_s8[l];
		end
		coin_s9 <= coin_s8;
		cr_s9   <= cr_s8;
	end

	// Stage 10: combine and drop the mass fraction
	logic [63:0] psum_c [LANES];
	logic [34:0] dmag_s10 [LANES];
	logic        lsg_s10  [LANES];
	logic        coin_s10;
	carry_t      cr_s10;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			psum_c[l] = {phi_s9[l], 17'b0} + 64'(plo_s9[l]);
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			dmag_s10[l] <= psum_c[l][MASS_FRAC+34:MASS_FRAC];
			lsg_s10[l]  <= lsg_s9[l];
		end
		coin_s10 <= coin_s9;
		cr_s10   <= cr_s9;
	end

	// Stage 11: apply the velocity change
	logic signed [31:0] vel_c [LANES];
	logic [36:0]        ve_c  [LANES];
	logic [36:0]        me_c  [LANES];
	logic               add_c [LANES];
	logic signed [36:0] u_s11 [LANES];
	logic               coin_s11;
	logic [16:0]        ea_s11, eb_s11;

	always_comb begin
		vel_c[0] = cr_s10.avx;
		vel_c[1] = cr_s10.avy;
		vel_c[2] = cr_s10.bvx;
		vel_c[3] = cr_s10.bvy;
		for (int l = 0; l < LANES; l++) begin
			ve_c[l]  = {{5{vel_c[l][31]}}, vel_c[l]};
			me_c[l]  = {2'b0, dmag_s10[l]};
			// ball A subtracts the change, ball B adds it
			add_c[l] = lsg_s10[l] ^ (l >= 2);
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (coin_s10) begin
				u_s11[l] <= ve_c[l];
			end else if (add_c[l]) begin
				u_s11[l] <= ve_c[l] + me_c[l];
			end else begin
				u_s11[l] <= ve_c[l] - me_c[l];
			end
		end
		coin_s11 <= coin_s10;
		ea_s11   <= cr_s10.ea;
		eb_s11   <= cr_s10.eb;
	end

	// Stage 12: magnitude of the new velocity
	logic [35:0] umag_s12 [LANES];
	logic        usg_s12  [LANES];
	logic        coin_s12;
	logic [16:0] ea_s12, eb_s12;

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			umag_s12[l] <= u_s11[l][36] ? 36'(-u_s11[l]) : 36'(u_s11[l]);
			usg_s12[l]  <= u_s11[l][36];
		end
		coin_s12 <= coin_s11;
		ea_s12   <= ea_s11;
		eb_s12   <= eb_s11;
	end

	// Stage 13: elasticity scaling
	logic [52:0] prod_s13 [LANES];
	logic        usg_s13  [LANES];
	logic        coin_s13;

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			prod_s13[l] <= umag_s12[l] * ((l < 2) ? ea_s12 : eb_s12);
			usg_s13[l]  <= usg_s12[l];
		end
		coin_s13 <= coin_s12;
	end

	// Stage 14: truncate, saturate and hold the result beat
	logic [36:0] rmag_c [LANES];
	logic [31:0] rval_c [LANES];
	logic        rsat_c [LANES];
	result_t     res_s14;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rmag_c[l] = prod_s13[l][52:ELAST_FRAC];
			if (!usg_s13[l] && rmag_c[l] > 37'(SAT_MAX)) begin
				rval_c[l] = SAT_MAX;
				rsat_c[l] = 1'b1;
			end else if (usg_s13[l] && rmag_c[l] > 37'(SAT_MIN)) begin
				rval_c[l] = SAT_MIN;
				rsat_c[l] = 1'b1;
			end else begin
				rval_c[l] = usg_s13[l] ? 32'(-rmag_c[l]) : rmag_c[l][31:0];
				rsat_c[l] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s14.new_a_vx         <= rval_c[0];
		res_s14.new_a_vy         <= rval_c[1];
		res_s14.new_b_vx         <= rval_c[2];
		res_s14.new_b_vy         <= rval_c[3];
		res_s14.centers_coincide <= coin_s13;
		res_s14.saturated        <= rsat_c[0] | rsat_c[1] | rsat_c[2] | rsat_c[3];
	end

	assign result = res_s14;

`ifndef NO_ASSERTIONS
	// Normalized direction has its leading one at the target position
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[2] && !coin_s3 |-> nmx_s3[NRM_MSB] || nmy_s3[NRM_MSB])
		else $error("direction not normalized");

	// Squared norm stays in range, so the divisor is never zero
	a_norm2_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[4] && !coin_s5 |-> n2_s5[28:26] != 3'b000)
		else $error("squared norm out of range");

	// Mass factors never sum above two
	a_fact_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[PRE_STAGES+DIV_STAGES] && !tz_s8 |->
		({1'b0, lfac_s8[0]} + {1'b0, lfac_s8[2]}) <= {1'b0, FACT_TWO})
		else $error("mass factors out of range");

	// A saturated beat carries at least one clamped velocity
	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.saturated |->
		result.new_a_vx == SAT_MAX || result.new_a_vx == SAT_MIN ||
		result.new_a_vy == SAT_MAX || result.new_a_vy == SAT_MIN ||
		result.new_b_vx == SAT_MAX || result.new_b_vx == SAT_MIN ||
		result.new_b_vy == SAT_MAX || result.new_b_vy == SAT_MIN)
		else $error("saturated flag without a clamped velocity");
`endif

endmodule
